// ===== rtl/core/window_symbol_fsm_switch_controller_defines.svh =====
// Assertion macros for the window symbol switch controller.
// Define NO_ASSERTIONS to compile the checks out; uses i_clk and i_rst_n of the includer.
`ifndef WINDOW_SYMBOL_FSM_SWITCH_CONTROLLER_DEFINES_SVH
`define WINDOW_SYMBOL_FSM_SWITCH_CONTROLLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WSFC_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define WSFC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define WSFC_ASSERT_NOW(lbl, expr, msg)
`define WSFC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/core/wsfc_pkg.sv =====
// Shared types and constants of the window symbol switch controller.
// No dependencies; used by every module of the block except wsfc_table.
`default_nettype none

package wsfc_pkg;

    localparam int NUM_SYMBOLS = 9;

    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [1:0] CLS_BELOW  = 2'd0;
    localparam logic [1:0] CLS_ABOVE  = 2'd1;
    localparam logic [1:0] CLS_INSIDE = 2'd2;

    localparam logic [2:0] CFG_TARGET_VOLTAGE = 3'd0;
    localparam logic [2:0] CFG_TARGET_CURRENT = 3'd1;
    localparam logic [2:0] CFG_VOLTAGE_BAND   = 3'd2;
    localparam logic [2:0] CFG_CURRENT_BAND   = 3'd3;
    localparam logic [2:0] CFG_INITIAL_STATE  = 3'd4;

    localparam logic signed [15:0] RST_TARGET_VOLTAGE = 16'sd3410;
    localparam logic signed [15:0] RST_TARGET_CURRENT = 16'sd1229;
    localparam logic [14:0]        RST_BAND           = 15'd102;
    localparam logic [2:0]         RST_INITIAL_STATE  = 3'd0;

    localparam logic [2:0] SWITCH_A_STATE = 3'd1;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] voltage;
        logic signed [15:0] current;
        logic [2:0]         entry_state;
        logic [3:0]         entry_symbol;
        logic [2:0]         entry_next;
    } t_in_item;

    typedef struct packed {
        logic [2:0] present_state;
        logic [3:0] symbol;
        logic       symbol_taken;
        logic       switch_a_on;
        logic       switch_b_on;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] target_voltage;
        logic signed [15:0] target_current;
        logic [14:0]        voltage_band;
        logic [14:0]        current_band;
    } t_window_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/window_symbol_fsm_switch_controller.sv =====
// Window symbol switch controller, top level: config registers, pipeline, state.
// Depends on wsfc_pkg, wsfc_classify, wsfc_table and the assertion header.
//
// Usage:
//   Requests enter on i_in_valid/o_in_ready with i_in_item; each request yields
//   exactly one result on o_out_valid/i_out_ready with o_out_item.
//   Command sample classes voltage and current and may step the state through
//   the transition table; command write loads one table entry; command restart
//   reloads the initial state.
//   A request passes stage 1, stage 2 and the result register in that order.
//   Throughput: one request per clock, sustained while i_out_ready stays high.
//   The table address of a sample is built from the state forwarded from the
//   request one stage ahead, and the memory's registered read gives the entry in stage 2.
//   Stall: while i_out_ready is low and the result register is full, the stages
//   hold; o_in_ready drops only when every stage is occupied.
//   Reset (synchronous, i_rst_n low): config registers take their defaults, the
//   state is the initial state, the repeat filter clears. The table is not
//   cleared and must be written before it is used; no clearing pass runs.
//   Config writes (i_cfg_we) are taken at any edge and belong in idle periods.
`default_nettype none
`include "window_symbol_fsm_switch_controller_defines.svh"

module window_symbol_fsm_switch_controller #(
    parameter int NUM_STATES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire wsfc_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output wsfc_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);

    localparam int DEPTH = NUM_STATES * wsfc_pkg::NUM_SYMBOLS;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    wsfc_pkg::t_window_cfg r_win;
    logic [2:0]            r_init_state;

    // pipeline
    logic                 r_s1_valid;
    wsfc_pkg::t_in_item   r_s1_item;
    logic                 r_s2_valid;
    logic [1:0]           r_s2_cmd;
    logic [3:0]           r_s2_sym;
    logic                 r_s2_taken;
    logic                 r_out_valid;
    wsfc_pkg::t_out_item  r_out_item;

    // controller state
    logic [2:0] r_state;
    logic [3:0] r_last_sym;
    logic       r_last_valid;
    logic       r_first;

    logic       s2_adv;
    logic       s1_adv;
    logic       in_acc;
    logic [2:0] start_state;
    logic [2:0] s2_next;
    logic [3:0] s1_sym;
    logic       s1_is_sample;
    logic       s1_taken;
    logic       s1_fire;
    logic       wr_ok;
    logic       tbl_we;
    logic       tbl_re;
    logic [AW-1:0] tbl_waddr;
    logic [AW-1:0] tbl_raddr;
    logic [2:0]    tbl_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.target_voltage <= wsfc_pkg::RST_TARGET_VOLTAGE;
            r_win.target_current <= wsfc_pkg::RST_TARGET_CURRENT;
            r_win.voltage_band   <= wsfc_pkg::RST_BAND;
            r_win.current_band   <= wsfc_pkg::RST_BAND;
            r_init_state         <= wsfc_pkg::RST_INITIAL_STATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wsfc_pkg::CFG_TARGET_VOLTAGE: r_win.target_voltage <= $signed(i_cfg_data);
                wsfc_pkg::CFG_TARGET_CURRENT: r_win.target_current <= $signed(i_cfg_data);
                wsfc_pkg::CFG_VOLTAGE_BAND:   r_win.voltage_band   <= i_cfg_data[14:0];
                wsfc_pkg::CFG_CURRENT_BAND:   r_win.current_band   <= i_cfg_data[14:0];
                wsfc_pkg::CFG_INITIAL_STATE:  r_init_state         <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    wsfc_classify u_classify (
        .i_voltage (r_s1_item.voltage),
        .i_current (r_s1_item.current),
        .i_cfg     (r_win),
        .o_symbol  (s1_sym)
    );

    wsfc_table #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (wsfc_pkg::NUM_SYMBOLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (r_s1_item.entry_next),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    always_comb begin
        s2_adv     = !r_out_valid || i_out_ready;
        s1_adv     = !r_s2_valid || s2_adv;
        o_in_ready = !r_s1_valid || s1_adv;
        in_acc     = i_in_valid && o_in_ready;

        // saturate an out-of-range initial state
        start_state = (32'(r_init_state) >= NUM_STATES) ? 3'(NUM_STATES - 1) : r_init_state;

        priority if (r_s2_valid && (r_s2_cmd == wsfc_pkg::CMD_SAMPLE) && r_s2_taken) begin
            s2_next = tbl_rdata;
        end else if (r_s2_valid && (r_s2_cmd == wsfc_pkg::CMD_RESTART)) begin
            s2_next = start_state;
        end else begin
            s2_next = r_state;
        end

        s1_fire      = r_s1_valid && s1_adv;
        s1_is_sample = r_s1_item.command == wsfc_pkg::CMD_SAMPLE;
        s1_taken     = s1_is_sample && (r_first || !r_last_valid || (s1_sym != r_last_sym));

        // read with the state the request ahead leaves behind
        tbl_re    = s1_fire && s1_taken;
        tbl_raddr = AW'(s2_next) * AW'(wsfc_pkg::NUM_SYMBOLS) + AW'(s1_sym);

        wr_ok     = (32'(r_s1_item.entry_state) < NUM_STATES)
                 && (32'(r_s1_item.entry_symbol) < wsfc_pkg::NUM_SYMBOLS)
                 && (32'(r_s1_item.entry_next) < NUM_STATES);
        tbl_we    = s1_fire && (r_s1_item.command == wsfc_pkg::CMD_WRITE) && wr_ok;
        tbl_waddr = AW'(r_s1_item.entry_state) * AW'(wsfc_pkg::NUM_SYMBOLS)
                  + AW'(r_s1_item.entry_symbol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= wsfc_pkg::RST_INITIAL_STATE;
            r_last_sym   <= '0;
            r_last_valid <= 1'b0;
            r_first      <= 1'b1;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s2_adv) begin
                r_out_valid <= r_s2_valid;
            end
            if (r_s2_valid && s2_adv) begin
                r_state <= s2_next;
            end
            if (s1_fire && s1_is_sample) begin
                r_first <= 1'b0;
                if (s1_taken) begin
                    r_last_sym   <= s1_sym;
                    r_last_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_item;
        end
        if (s1_adv) begin
            r_s2_cmd   <= r_s1_item.command;
            r_s2_sym   <= s1_is_sample ? s1_sym : 4'd0;
            r_s2_taken <= s1_taken;
        end
        if (r_s2_valid && s2_adv) begin
            r_out_item.present_state <= s2_next;
            r_out_item.symbol        <= r_s2_sym;
            r_out_item.symbol_taken  <= r_s2_taken;
            r_out_item.switch_a_on   <= s2_next == wsfc_pkg::SWITCH_A_STATE;
            r_out_item.switch_b_on   <= s2_next != wsfc_pkg::SWITCH_A_STATE;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `WSFC_ASSERT_NOW(a_state_range, !o_out_valid || (32'(o_out_item.present_state) < NUM_STATES), "state out of range")
    `WSFC_ASSERT_NOW(a_taken_sample, !(r_s2_valid && r_s2_taken) || (r_s2_cmd == wsfc_pkg::CMD_SAMPLE), "non-sample request marked taken")
    `WSFC_ASSERT_NEXT(a_state_hold, !(r_s2_valid && s2_adv), $stable(r_state), "state moved without a commit")
    `WSFC_ASSERT_NEXT(a_state_commit, r_s2_valid && s2_adv, o_out_item.present_state == r_state, "result state differs from committed state")

endmodule

`default_nettype wire

// ===== rtl/core/wsfc_classify.sv =====
// Window classifier: turns a voltage and current sample into a symbol 0..8.
// Depends on wsfc_pkg for the window settings type and class codes.
`default_nettype none

module wsfc_classify (
    input  wire logic signed [15:0]  i_voltage,
    input  wire logic signed [15:0]  i_current,
    input  wire wsfc_pkg::t_window_cfg i_cfg,
    output logic [3:0]               o_symbol
);

    function automatic logic [1:0] class_of(input logic signed [15:0] value,
                                            input logic signed [15:0] target,
                                            input logic [14:0]        band);
        logic signed [17:0] v;
        logic signed [17:0] b;
        logic signed [17:0] lo;
        logic signed [17:0] hi;
        v  = 18'(value);
        b  = $signed({3'b000, band});
        lo = 18'(target) - b;
        hi = 18'(target) + b;
        // edges count as inside
        if (v < lo) begin
            return wsfc_pkg::CLS_BELOW;
        end else if (v > hi) begin
            return wsfc_pkg::CLS_ABOVE;
        end
        return wsfc_pkg::CLS_INSIDE;
    endfunction

    logic [1:0] v_cls;
    logic [1:0] c_cls;

    always_comb begin
        v_cls    = class_of(i_voltage, i_cfg.target_voltage, i_cfg.voltage_band);
        c_cls    = class_of(i_current, i_cfg.target_current, i_cfg.current_band);
        o_symbol = 4'({v_cls, 1'b0}) + 4'(v_cls) + 4'(c_cls);
    end

endmodule

`default_nettype wire

// ===== rtl/core/wsfc_table.sv =====
// Transition table memory: one write port, one read port, registered read data.
// No package dependency; contents are undefined until written.
`default_nettype none

module wsfc_table #(
    parameter int NUM_STATES = 8,
    parameter int NUM_SYMBOLS = 9
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [$clog2(NUM_STATES*NUM_SYMBOLS)-1:0]   i_waddr,
    input  wire logic [2:0]                                  i_wdata,
    input  wire logic                                        i_re,
    input  wire logic [$clog2(NUM_STATES*NUM_SYMBOLS)-1:0]   i_raddr,
    output logic [2:0]                                       o_rdata
);

    localparam int DEPTH = NUM_STATES * NUM_SYMBOLS;

    logic [2:0] mem [DEPTH];
    logic [2:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sim/wsfc_result_checker.sv =====
// Result checker for the window symbol switch controller testbench.
// Mirrors config writes, predicts each request's result and compares it in order.
// Depends on wsfc_pkg for the payload types, codes and reset values.
module wsfc_result_checker #(
    parameter int NUM_STATES = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire wsfc_pkg::t_in_item  i_in_item,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire wsfc_pkg::t_out_item i_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    output int                       o_mismatches,
    output int                       o_pending,
    output int                       o_results
);

    // mirrored window configuration
    logic signed [15:0] tgt_v;
    logic signed [15:0] tgt_c;
    logic [14:0]        band_v;
    logic [14:0]        band_c;
    logic [2:0]         init_st;

    // mirrored controller state
    logic [2:0] cur_state;
    logic [3:0] prev_sym;
    logic       prev_sym_ok;
    logic       first_smp;
    logic [2:0] next_tab [NUM_STATES][wsfc_pkg::NUM_SYMBOLS];

    wsfc_pkg::t_out_item expected_results[$];
    int                  mismatch_cnt;
    int                  result_cnt;

    function automatic logic [1:0] classify_value(int value, int target, int band);
        if (value < target - band) return wsfc_pkg::CLS_BELOW;
        if (value > target + band) return wsfc_pkg::CLS_ABOVE;
        return wsfc_pkg::CLS_INSIDE;
    endfunction

    function automatic logic [2:0] load_state();
        return (int'(init_st) >= NUM_STATES) ? 3'(NUM_STATES - 1) : init_st;
    endfunction

    // Advance the mirrored state by one request and return its result.
    function automatic wsfc_pkg::t_out_item step_controller(wsfc_pkg::t_in_item it);
        wsfc_pkg::t_out_item r;
        logic [3:0]          sym;
        r   = '0;
        sym = '0;
        unique case (it.command)
            wsfc_pkg::CMD_SAMPLE: begin
                sym = 4'(3 * classify_value(it.voltage, tgt_v, band_v)
                         + classify_value(it.current, tgt_c, band_c));
                // drop a repeated symbol, but never the first sample
                if (first_smp || !prev_sym_ok || sym != prev_sym) begin
                    r.symbol_taken = 1'b1;
                    if (int'(cur_state) < NUM_STATES) cur_state = next_tab[cur_state][sym];
                    prev_sym    = sym;
                    prev_sym_ok = 1'b1;
                end
                first_smp = 1'b0;
            end
            wsfc_pkg::CMD_WRITE: begin
                if (int'(it.entry_state) < NUM_STATES
                        && int'(it.entry_symbol) < wsfc_pkg::NUM_SYMBOLS
                        && int'(it.entry_next) < NUM_STATES)
                    next_tab[it.entry_state][it.entry_symbol] = it.entry_next;
            end
            wsfc_pkg::CMD_RESTART: cur_state = load_state();
            default: ;
        endcase
        r.present_state = cur_state;
        r.symbol        = sym;
        r.switch_a_on   = (cur_state == wsfc_pkg::SWITCH_A_STATE);
        r.switch_b_on   = (cur_state != wsfc_pkg::SWITCH_A_STATE);
        return r;
    endfunction

    always @(posedge i_clk) begin
        wsfc_pkg::t_out_item want;
        logic                bad;
        if (!i_rst_n) begin
            tgt_v       = wsfc_pkg::RST_TARGET_VOLTAGE;
            tgt_c       = wsfc_pkg::RST_TARGET_CURRENT;
            band_v      = wsfc_pkg::RST_BAND;
            band_c      = wsfc_pkg::RST_BAND;
            init_st     = wsfc_pkg::RST_INITIAL_STATE;
            cur_state   = load_state();
            prev_sym    = '0;
            prev_sym_ok = 1'b0;
            first_smp   = 1'b1;
            for (int s = 0; s < NUM_STATES; s++)
                for (int y = 0; y < wsfc_pkg::NUM_SYMBOLS; y++)
                    next_tab[s][y] = '0;
            expected_results.delete();
            mismatch_cnt = 0;
            result_cnt   = 0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wsfc_pkg::CFG_TARGET_VOLTAGE: tgt_v   = i_cfg_data;
                    wsfc_pkg::CFG_TARGET_CURRENT: tgt_c   = i_cfg_data;
                    wsfc_pkg::CFG_VOLTAGE_BAND:   band_v  = i_cfg_data[14:0];
                    wsfc_pkg::CFG_CURRENT_BAND:   band_c  = i_cfg_data[14:0];
                    wsfc_pkg::CFG_INITIAL_STATE:  init_st = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                result_cnt++;
                if (expected_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("[%0t] result with no request pending: state %0d symbol %0d",
                                 $realtime, i_out_item.present_state, i_out_item.symbol);
                end else begin
                    want = expected_results.pop_front();
                    bad  = (i_out_item.present_state !== want.present_state)
                        || (i_out_item.symbol !== want.symbol)
                        || (i_out_item.symbol_taken !== want.symbol_taken)
                        || (i_out_item.switch_a_on !== want.switch_a_on)
                        || (i_out_item.switch_b_on !== want.switch_b_on);
                    if (bad) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"[%0t] mismatch: expected state %0d sym %0d taken %b a %b b %b,",
                                      " got state %0d sym %0d taken %b a %b b %b"}, $realtime,
                                     want.present_state, want.symbol, want.symbol_taken,
                                     want.switch_a_on, want.switch_b_on,
                                     i_out_item.present_state, i_out_item.symbol,
                                     i_out_item.symbol_taken, i_out_item.switch_a_on,
                                     i_out_item.switch_b_on);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.insert(expected_results.size(), step_controller(i_in_item));
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= expected_results.size();
        o_results    <= result_cnt;
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the window symbol switch controller: clock, reset, stimulus, verdict.
// Depends on wsfc_pkg, the controller RTL and wsfc_result_checker.
module tb_top;

    localparam int NUM_STATES      = 8;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASE_ITEMS     = 105;
    localparam int WATCHDOG_CYCLES = 400000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                out_ready = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [15:0]         cfg_data  = '0;
    wsfc_pkg::t_in_item  in_item   = '0;
    logic                in_ready;
    logic                out_valid;
    wsfc_pkg::t_out_item out_item;

    int mismatches;
    int pending;
    int results;

    // stimulus copy of the window, used to aim samples at the edges
    int                 win_tv = wsfc_pkg::RST_TARGET_VOLTAGE;
    int                 win_tc = wsfc_pkg::RST_TARGET_CURRENT;
    int                 win_vb = wsfc_pkg::RST_BAND;
    int                 win_cb = wsfc_pkg::RST_BAND;
    logic               calm   = 1'b0;
    int                 sent_items = 0;
    wsfc_pkg::t_in_item last_sample = '0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    window_symbol_fsm_switch_controller #(
        .NUM_STATES(NUM_STATES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    wsfc_result_checker #(
        .NUM_STATES(NUM_STATES)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_results   (results)
    );

    // Result side: random stalls, plus two long hold-offs while requests keep coming.
    initial begin : result_sink
        int   hold_left;
        int   holds_done;
        logic start_hold;
        logic quiet;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge clk);
            start_hold = (hold_left == 0) && (holds_done < 2) && in_valid && !calm
                      && (results >= 250 + 250 * holds_done);
            quiet = calm;
            @(negedge clk);
            if (start_hold) begin
                hold_left = HOLD_OFF_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                out_ready = 1'b0;
                hold_left--;
            end else begin
                out_ready = quiet ? 1'b1 : ($urandom_range(99) >= 6);
            end
        end
    end

    function automatic wsfc_pkg::t_in_item item_of(logic [1:0] cmd, int v, int c, int row,
                                                   int col, int nxt);
        wsfc_pkg::t_in_item it;
        it.command      = cmd;
        it.voltage      = v[15:0];
        it.current      = c[15:0];
        it.entry_state  = row[2:0];
        it.entry_symbol = col[3:0];
        it.entry_next   = nxt[2:0];
        return it;
    endfunction

    // Pick a value near a window edge, at the target, inside, or anywhere.
    function automatic int aim_value(int target, int band);
        int pick;
        int v;
        pick = $urandom_range(9);
        unique case (pick)
            0, 1, 2: v = $urandom_range(65535);
            3, 4:    v = target - band - 1 + $urandom_range(2);
            5, 6:    v = target + band - 1 + $urandom_range(2);
            7:       v = target;
            default: v = target - band + $urandom_range(2 * band);
        endcase
        return v;
    endfunction

    function automatic wsfc_pkg::t_in_item random_request();
        wsfc_pkg::t_in_item it;
        int                 pick;
        it   = item_of(wsfc_pkg::CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom);
        pick = $urandom_range(99);
        if (pick < 70) begin
            // repeat a previous sample now and then so the filter drops it
            if ($urandom_range(99) < 20) begin
                it.voltage = last_sample.voltage;
                it.current = last_sample.current;
            end else begin
                it.voltage = 16'(aim_value(win_tv, win_vb));
                it.current = 16'(aim_value(win_tc, win_cb));
            end
            last_sample = it;
        end else if (pick < 88) begin
            it.command = wsfc_pkg::CMD_WRITE;
            if ($urandom_range(99) < 85)
                it.entry_symbol = 4'($urandom_range(wsfc_pkg::NUM_SYMBOLS - 1));
        end else if (pick < 96) begin
            it.command = wsfc_pkg::CMD_RESTART;
        end else begin
            it.command = wsfc_pkg::CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic offer(input wsfc_pkg::t_in_item it);
        if (!calm && $urandom_range(99) < 6) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item  = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent_items++;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val[15:0];
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic run_phase(input int tv, input int tc, input int vb, input int cb,
                             input int init, input bit quiet_start);
        int done;
        wait_idle();
        write_reg(wsfc_pkg::CFG_TARGET_VOLTAGE, tv);
        write_reg(wsfc_pkg::CFG_TARGET_CURRENT, tc);
        write_reg(wsfc_pkg::CFG_VOLTAGE_BAND, vb);
        write_reg(wsfc_pkg::CFG_CURRENT_BAND, cb);
        write_reg(wsfc_pkg::CFG_INITIAL_STATE, init);
        win_tv = tv;
        win_tc = tc;
        win_vb = vb;
        win_cb = cb;
        calm   = quiet_start;
        // load the new initial state before random traffic
        offer(item_of(wsfc_pkg::CMD_RESTART, $urandom, $urandom, $urandom, $urandom,
                      $urandom));
        done = 0;
        while (done < PHASE_ITEMS) begin
            wsfc_pkg::t_in_item it;
            it = random_request();
            offer(it);
            if (it.command != wsfc_pkg::CMD_UNUSED) done++;
            if (done == 100) calm = 1'b0;
            if (done == PHASE_ITEMS / 2 && $urandom_range(1)) wait_idle();
        end
    endtask

    initial begin : stimulus
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // fill the whole transition table before any sample reads it
        for (int s = 0; s < NUM_STATES; s++)
            for (int y = 0; y < wsfc_pkg::NUM_SYMBOLS; y++)
                offer(item_of(wsfc_pkg::CMD_WRITE, $urandom, $urandom, s, y,
                              $urandom_range(7)));

        // directed: first sample with symbol 0, repeats, extremes, window edges
        offer(item_of(wsfc_pkg::CMD_SAMPLE, -32768, -32768, 0, 0, 0));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, -32768, -32768, 7, 15, 7));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, 32767, 32767, 0, 0, 0));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, win_tv - win_vb, win_tc + win_cb, 0, 0, 0));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, win_tv - win_vb - 1, win_tc + win_cb + 1, 0, 0, 0));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, win_tv + win_vb + 1, win_tc - win_cb - 1, 0, 0, 0));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, win_tv + win_vb, win_tc - win_cb, 0, 0, 0));
        // out-of-range table columns are dropped
        offer(item_of(wsfc_pkg::CMD_WRITE, 0, 0, 7, 15, 5));
        offer(item_of(wsfc_pkg::CMD_WRITE, -1, -1, 0, 9, 3));
        offer(item_of(wsfc_pkg::CMD_RESTART, 0, 0, 0, 0, 0));
        // write then read the same entry back to back
        offer(item_of(wsfc_pkg::CMD_WRITE, 0, 0, 0, 2, 1));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, win_tv - win_vb - 1, win_tc, 0, 0, 0));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, win_tv - win_vb - 1, win_tc, 0, 0, 0));
        offer(item_of(wsfc_pkg::CMD_UNUSED, -1, -1, 7, 15, 7));
        offer(item_of(wsfc_pkg::CMD_WRITE, 0, 0, 1, 8, 7));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, win_tv, win_tc, 0, 0, 0));
        offer(item_of(wsfc_pkg::CMD_WRITE, 0, 0, 7, 4, 0));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, 32767, 32767, 0, 0, 0));
        offer(item_of(wsfc_pkg::CMD_SAMPLE, -32768, 32767, 0, 0, 0));
        offer(item_of(wsfc_pkg::CMD_RESTART, -1, -1, 7, 15, 7));
        offer(item_of(wsfc_pkg::CMD_UNUSED, 0, 0, 0, 0, 0));

        run_phase(wsfc_pkg::RST_TARGET_VOLTAGE, wsfc_pkg::RST_TARGET_CURRENT,
                  wsfc_pkg::RST_BAND, wsfc_pkg::RST_BAND, wsfc_pkg::RST_INITIAL_STATE, 1'b0);
        run_phase(-32768, 32767, 0, 32767, 7, 1'b1);
        run_phase(32767, -32768, 32767, 0, 1, 1'b0);
        run_phase(0, 0, 3, 3, 5, 1'b0);
        run_phase($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                  $urandom_range(2000), $urandom_range(2000), $urandom_range(7), 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d requests (table fill, directed, five window settings),",
                 sent_items);
        $display("%0d results checked, with long output stalls and idle drains", results);
        if (mismatches == 0 && pending == 0) begin
            $display("** window_symbol_fsm_switch_controller: PASSED **");
        end else begin
            $display("** window_symbol_fsm_switch_controller: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_CYCLES * 20);
        $display("** window_symbol_fsm_switch_controller: FAILED **");
        $finish;
    end

endmodule
